/* hw/rtl/rmg_pkg.sv */
`default_nettype none
package rmg_pkg;

	// angle format
	localparam int unsigned FRAC_BITS = 16;
	localparam logic [32:0] FULL      = 33'(360) << FRAC_BITS;
	localparam logic [32:0] QUARTER   = 33'(90) << FRAC_BITS;
	// multiple of a full turn that lifts any 32-bit angle above zero
	localparam logic [33:0] OFFSET    = 34'(92) * 34'(FULL);
	localparam int unsigned QBITS     = 11;

	// radians per degree, Q30
	localparam logic [24:0] DEG2RAD   = 25'd18740330;
	localparam logic signed [33:0] GAIN = 34'sh26DD3B6A;
	localparam int unsigned ATAN_N    = 24;

	localparam logic [31:0] ATAN_Q30 [ATAN_N] = '{
		32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76,
		32'h01FFD55B, 32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD,
		32'h000FFFFF, 32'h0007FFFF, 32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF,
		32'h00007FFF, 32'h00003FFF, 32'h00001FFF, 32'h00000FFF, 32'h000007FF,
		32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F
	};

	localparam logic [1:0] OP_ROT_X = 2'd0;
	localparam logic [1:0] OP_ROT_Y = 2'd1;
	localparam logic [1:0] OP_ROT_Z = 2'd2;
	localparam logic [1:0] OP_QUAT  = 2'd3;

	typedef struct packed {
		logic [1:0]         op;
		logic signed [15:0] qw;
		logic signed [15:0] qx;
		logic signed [15:0] qy;
		logic signed [15:0] qz;
		logic [32:0]        rem;
		logic [1:0]         quad;
		logic signed [32:0] z;
		logic signed [33:0] x;
		logic signed [33:0] y;
	} pipe_t;

	// round half up by sh bits, then clamp to the 20-bit output range
	function automatic logic signed [19:0] rnd_sat(input logic signed [35:0] v,
			input int unsigned sh);
		logic signed [35:0] r;
		r = (v + (36'sd1 <<< (sh - 1))) >>> sh;
		if (r > 36'sd524287) begin
			return 20'sd524287;
		end else if (r < -36'sd524288) begin
			return -20'sd524288;
		end
		return r[19:0];
	endfunction

endpackage
`default_nettype wire

/* hw/rtl/rotation_matrix_generator.sv */
// Rotation matrix generator: one 3x3 matrix (Q.16, 20-bit, saturated) per input word.
// Slave channel s_tvalid/s_tready/s_tdata carries opcode, angle and quaternion;
// master channel m_tvalid/m_tready/m_tdata carries the nine elements row-major.
// Opcodes 0..2 rotate about X, Y, Z by angle_deg; opcode 3 builds the matrix
// from a quaternion, which the block does not normalize.
// A word passes CORDIC_STEPS + 15 register stages: one input stage, eleven
// quotient-bit stages of the modulo-90 reduction, one degree-to-radian multiply,
// CORDIC_STEPS rotation stages, one rounding and product stage, one output stage.
// Throughput: one word per cycle while the receiver does not stall; every stage
// is a register stage of the pipe.
// Reset clears all valid bits; payload registers are not reset.
// When the receiver stalls, the whole pipe holds and s_tready drops; a word in
// the output register stays there unchanged until taken. Nothing is lost or
// repeated.
`default_nettype none
module rotation_matrix_generator #(
	parameter int CORDIC_STEPS = 16
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	// opcode[1:0], angle_deg[33:2], quat_w[49:34], quat_x[65:50],
	// quat_y[81:66], quat_z[97:82], zero fill [103:98]
	input  wire logic [103:0] s_tdata,
	output logic              m_tvalid,
	input  wire logic         m_tready,
	// m00[19:0], m01[39:20], m02[59:40], m10[79:60], m11[99:80],
	// m12[119:100], m20[139:120], m21[159:140], m22[179:160], zero fill [183:180]
	output logic [183:0]      m_tdata
);

	localparam int L = rmg_pkg::QBITS + 1 + CORDIC_STEPS;

	logic              en;
	logic [L:0]        vld_s;
	rmg_pkg::pipe_t    pl_s [L+1];
	rmg_pkg::pipe_t    nx [L+1];

	// advance whenever the output register is free or being emptied
	assign en       = !m_tvalid || m_tready;
	assign s_tready = en;

	// input stage: lift angle to a positive value of the same residue
	always_comb begin
		logic signed [33:0] a34;
		a34 = {{2{s_tdata[33]}}, s_tdata[33:2]};
		nx[0]      = '0;
		nx[0].op   = s_tdata[1:0];
		nx[0].qw   = s_tdata[49:34];
		nx[0].qx   = s_tdata[65:50];
		nx[0].qy   = s_tdata[81:66];
		nx[0].qz   = s_tdata[97:82];
		nx[0].rem  = 33'(a34 + $signed(rmg_pkg::OFFSET));
		nx[0].quad = 2'd0;
	end

	// restoring division by 90 degrees, one quotient bit per stage
	for (genvar k = 1; k <= rmg_pkg::QBITS; k++) begin : g_div
		localparam int B = rmg_pkg::QBITS - k;
		localparam logic [32:0] DV = rmg_pkg::QUARTER << B;
		always_comb begin
			nx[k] = pl_s[k-1];
			if (pl_s[k-1].rem >= DV) begin
				nx[k].rem = pl_s[k-1].rem - DV;
				if (B < 2) begin
					nx[k].quad[B%2] = 1'b1;
				end
			end
		end
	end

	// degrees to Q30 radians, seed the rotation
	always_comb begin
		logic [47:0] prod;
		prod = 48'(pl_s[rmg_pkg::QBITS].rem[22:0]) * 48'(rmg_pkg::DEG2RAD);
		nx[rmg_pkg::QBITS+1]   = pl_s[rmg_pkg::QBITS];
		nx[rmg_pkg::QBITS+1].z = $signed({1'b0, prod[47:16]});
		nx[rmg_pkg::QBITS+1].x = rmg_pkg::GAIN;
		nx[rmg_pkg::QBITS+1].y = '0;
	end

	// CORDIC rotation, one micro-rotation per stage
	for (genvar j = 0; j < CORDIC_STEPS; j++) begin : g_cordic
		localparam int P = rmg_pkg::QBITS + 1 + j;
		localparam logic signed [32:0] AT = $signed({1'b0, rmg_pkg::ATAN_Q30[j]});
		always_comb begin
			nx[P+1] = pl_s[P];
			if (!pl_s[P].z[32]) begin
				nx[P+1].x = pl_s[P].x - (pl_s[P].y >>> j);
				nx[P+1].y = pl_s[P].y + (pl_s[P].x >>> j);
				nx[P+1].z = pl_s[P].z - AT;
			end else begin
				nx[P+1].x = pl_s[P].x + (pl_s[P].y >>> j);
				nx[P+1].y = pl_s[P].y - (pl_s[P].x >>> j);
				nx[P+1].z = pl_s[P].z + AT;
			end
		end
	end

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[L-1:0], s_tvalid};
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i <= L; i++) begin
				pl_s[i] <= nx[i];
			end
		end
	end

	// rounding stage: map quadrant, round sine/cosine, form quaternion products
	logic               vld_s1;
	logic [1:0]         op_s1;
	logic signed [19:0] c_s1, sn_s1;
	logic signed [31:0] xx_s1, yy_s1, zz_s1, xw_s1, yw_s1, zw_s1, xy_s1, xz_s1, yz_s1;
	logic signed [33:0] cq, sq;

	always_comb begin
		case (pl_s[L].quad)
			2'd0: begin cq = pl_s[L].x;  sq = pl_s[L].y;  end
			2'd1: begin cq = -pl_s[L].y; sq = pl_s[L].x;  end
			2'd2: begin cq = -pl_s[L].x; sq = -pl_s[L].y; end
			default: begin cq = pl_s[L].y; sq = -pl_s[L].x; end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= vld_s[L];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			op_s1 <= pl_s[L].op;
			c_s1  <= rmg_pkg::rnd_sat(36'(cq), 30 - rmg_pkg::FRAC_BITS);
			sn_s1 <= rmg_pkg::rnd_sat(36'(sq), 30 - rmg_pkg::FRAC_BITS);
			xx_s1 <= pl_s[L].qx * pl_s[L].qx;
			yy_s1 <= pl_s[L].qy * pl_s[L].qy;
			zz_s1 <= pl_s[L].qz * pl_s[L].qz;
			xw_s1 <= pl_s[L].qx * pl_s[L].qw;
			yw_s1 <= pl_s[L].qy * pl_s[L].qw;
			zw_s1 <= pl_s[L].qz * pl_s[L].qw;
			xy_s1 <= pl_s[L].qx * pl_s[L].qy;
			xz_s1 <= pl_s[L].qx * pl_s[L].qz;
			yz_s1 <= pl_s[L].qy * pl_s[L].qz;
		end
	end

	// output stage: assemble the matrix
	localparam logic signed [19:0] ONE  = 20'sd1 <<< rmg_pkg::FRAC_BITS;
	localparam logic signed [35:0] ONE28 = 36'sd1 <<< 28;
	localparam int unsigned QSH = 28 - rmg_pkg::FRAC_BITS;

	logic signed [19:0] m [9];
	logic signed [19:0] m_s2 [9];
	logic               vld_s2;

	always_comb begin
		for (int i = 0; i < 9; i++) begin
			m[i] = (i == 0 || i == 4 || i == 8) ? ONE : 20'sd0;
		end
		case (op_s1)
			rmg_pkg::OP_ROT_X: begin
				m[4] = c_s1; m[5] = -sn_s1; m[7] = sn_s1; m[8] = c_s1;
			end
			rmg_pkg::OP_ROT_Y: begin
				m[0] = c_s1; m[2] = sn_s1; m[6] = -sn_s1; m[8] = c_s1;
			end
			rmg_pkg::OP_ROT_Z: begin
				m[0] = c_s1; m[1] = -sn_s1; m[3] = sn_s1; m[4] = c_s1;
			end
			default: begin
				m[0] = rmg_pkg::rnd_sat(ONE28 - ((36'(yy_s1) + 36'(zz_s1)) <<< 1), QSH);
				m[1] = rmg_pkg::rnd_sat((36'(xy_s1) - 36'(zw_s1)) <<< 1, QSH);
				m[2] = rmg_pkg::rnd_sat((36'(xz_s1) + 36'(yw_s1)) <<< 1, QSH);
				m[3] = rmg_pkg::rnd_sat((36'(xy_s1) + 36'(zw_s1)) <<< 1, QSH);
				m[4] = rmg_pkg::rnd_sat(ONE28 - ((36'(xx_s1) + 36'(zz_s1)) <<< 1), QSH);
				m[5] = rmg_pkg::rnd_sat((36'(yz_s1) - 36'(xw_s1)) <<< 1, QSH);
				m[6] = rmg_pkg::rnd_sat((36'(xz_s1) - 36'(yw_s1)) <<< 1, QSH);
				m[7] = rmg_pkg::rnd_sat((36'(yz_s1) + 36'(xw_s1)) <<< 1, QSH);
				m[8] = rmg_pkg::rnd_sat(ONE28 - ((36'(xx_s1) + 36'(yy_s1)) <<< 1), QSH);
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 9; i++) begin
				m_s2[i] <= m[i];
			end
		end
	end

	assign m_tvalid = vld_s2;
	assign m_tdata  = {4'd0, m_s2[8], m_s2[7], m_s2[6], m_s2[5], m_s2[4],
		m_s2[3], m_s2[2], m_s2[1], m_s2[0]};

	// checks
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready == (!m_tvalid || m_tready))
		else $error("ready does not follow output stall");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(vld_s) && $stable(vld_s1))
		else $error("pipe moved during stall");
	a_rem: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s[rmg_pkg::QBITS] |-> pl_s[rmg_pkg::QBITS].rem < rmg_pkg::QUARTER)
		else $error("angle reduction out of range");

endmodule
`default_nettype wire

/* test/testbench.sv */
`default_nettype none
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	// Matrix predictor: fixed-point rotation matrices per word, plus the queue of
	// matrices still owed by the block.
	class matrix_scoreboard;
		logic [179:0] owed[$];
		int errors;
		int checked;

		function new();
			errors = 0;
			checked = 0;
		endfunction

		static function longint asr(longint v, int s);
			return v >>> s;
		endfunction

		static function logic [19:0] round_sat(longint v, int from);
			int sh;
			longint r;
			sh = from - rmg_pkg::FRAC_BITS;
			r = asr(v + (longint'(1) << (sh - 1)), sh);
			if (r > 524287) r = 524287;
			if (r < -524288) r = -524288;
			return r[19:0];
		endfunction

		static function void sin_cos(logic signed [31:0] ang, output longint c,
				output longint s);
			longint full, quarter, r, q, rem, z, x, y, dx, dy;
			full = longint'(360) << 16;
			quarter = longint'(90) << 16;
			r = longint'(ang) % full;
			if (r < 0) r += full;
			q = r / quarter;
			rem = r - q * quarter;
			z = (rem * 18740330) >>> 16;
			x = 64'h26DD3B6A;
			y = 0;
			for (int i = 0; i < 16; i++) begin
				dx = asr(y, i);
				dy = asr(x, i);
				if (z >= 0) begin
					x -= dx; y += dy; z -= longint'(rmg_pkg::ATAN_Q30[i]);
				end else begin
					x += dx; y -= dy; z += longint'(rmg_pkg::ATAN_Q30[i]);
				end
			end
			case (q & 3)
				0: begin c = x; s = y; end
				1: begin c = -y; s = x; end
				2: begin c = -x; s = -y; end
				default: begin c = y; s = -x; end
			endcase
		endfunction

		static function logic [179:0] build_matrix(logic [103:0] d);
			longint m[9];
			longint w, x, y, z, one28;
			logic [179:0] packed_m;
			logic [1:0] op;
			op = d[1:0];
			for (int k = 0; k < 9; k++) m[k] = (k % 4 == 0) ? 65536 : 0;
			packed_m = '0;
			if (op != rmg_pkg::OP_QUAT) begin
				longint cc, ss;
				sin_cos(d[33:2], cc, ss);
				cc = longint'($signed(round_sat(cc, 30)));
				ss = longint'($signed(round_sat(ss, 30)));
				if (op == rmg_pkg::OP_ROT_X) begin
					m[4] = cc; m[5] = -ss; m[7] = ss; m[8] = cc;
				end else if (op == rmg_pkg::OP_ROT_Y) begin
					m[0] = cc; m[2] = ss; m[6] = -ss; m[8] = cc;
				end else begin
					m[0] = cc; m[1] = -ss; m[3] = ss; m[4] = cc;
				end
				for (int k = 0; k < 9; k++) packed_m[20*k +: 20] = m[k][19:0];
			end else begin
				w = longint'($signed(d[49:34]));
				x = longint'($signed(d[65:50]));
				y = longint'($signed(d[81:66]));
				z = longint'($signed(d[97:82]));
				one28 = longint'(1) << 28;
				packed_m[0 +: 20] = round_sat(one28 - 2 * (y*y + z*z), 28);
				packed_m[20 +: 20] = round_sat(2 * (x*y - z*w), 28);
				packed_m[40 +: 20] = round_sat(2 * (x*z + y*w), 28);
				packed_m[60 +: 20] = round_sat(2 * (x*y + z*w), 28);
				packed_m[80 +: 20] = round_sat(one28 - 2 * (x*x + z*z), 28);
				packed_m[100 +: 20] = round_sat(2 * (y*z - x*w), 28);
				packed_m[120 +: 20] = round_sat(2 * (x*z - y*w), 28);
				packed_m[140 +: 20] = round_sat(2 * (y*z + x*w), 28);
				packed_m[160 +: 20] = round_sat(one28 - 2 * (x*x + y*y), 28);
			end
			return packed_m;
		endfunction

		function void note_word(logic [103:0] d);
			owed.push_back(build_matrix(d));
		endfunction

		function void check_matrix(logic [183:0] got);
			logic [179:0] want;
			checked++;
			if (owed.size() == 0) begin
				errors++;
				$display("%0t: unexpected matrix %h", $time, got);
				return;
			end
			want = owed.pop_front();
			if (got[183:180] != 4'd0) begin
				errors++;
				$display("%0t: fill bits expected 0 actual %h", $time, got[183:180]);
			end
			for (int k = 0; k < 9; k++)
				if (got[20*k +: 20] != want[20*k +: 20]) begin
					errors++;
					$display("%0t: m%0d%0d expected %0d actual %0d", $time, k / 3, k % 3,
						$signed(want[20*k +: 20]), $signed(got[20*k +: 20]));
				end
		endfunction
	endclass

	localparam int WATCHDOG = 2000;
	localparam int RANDOM_WORDS = 650;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [103:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [183:0] m_tdata;

	matrix_scoreboard sb = new();
	logic [103:0] words[$];
	int idle_cycles = 0;
	int sent = 0;
	int n_quat = 0;

	rotation_matrix_generator u_top (.*);

	always #6 clk = ~clk;

	function automatic logic [103:0] pack_word(logic [1:0] op, logic [31:0] ang,
			logic [15:0] w, logic [15:0] x, logic [15:0] y, logic [15:0] z);
		return {6'd0, z, y, x, w, ang, op};
	endfunction

	// Q2.14 values: mostly within -1.0 to +1.0, sometimes anything
	function automatic logic [15:0] rand_q();
		if ($urandom_range(0, 3) == 0) return 16'($urandom());
		return 16'($signed($urandom_range(0, 32768)) - 16384);
	endfunction

	// drive every queued word; drop tvalid only before a gap or at the end
	task automatic send_words();
		logic [103:0] d;
		int gap;
		gap = $urandom_range(0, 4);
		while (words.size() > 0) begin
			d = words.pop_front();
			repeat (gap) @(posedge clk);
			s_tvalid <= 1'b1;
			s_tdata <= d;
			@(posedge clk);
			while (!s_tready) @(posedge clk);
			sb.note_word(d);
			sent++;
			if (d[1:0] == rmg_pkg::OP_QUAT) n_quat++;
			gap = $urandom_range(0, 4);
			if (words.size() == 0 || gap != 0) s_tvalid <= 1'b0;
		end
	endtask

	// receiver: random stalls per word
	initial begin
		int stall;
		@(posedge arst_n);
		forever begin
			stall = $urandom_range(0, 4);
			if (stall != 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			@(posedge clk);
			while (!m_tvalid) @(posedge clk);
			sb.check_matrix(m_tdata);
		end
	end

	// watchdog on cycles without any transfer on either channel
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles > WATCHDOG) begin
			$display("rotation_matrix_generator: mismatch");
			$finish;
		end
	end

	initial begin
		logic [31:0] ang;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// directed: angle extremes, quadrant edges, every opcode, quaternion extremes
		words.push_back(pack_word(rmg_pkg::OP_ROT_X, 32'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF,
			16'hFFFF));
		words.push_back(pack_word(rmg_pkg::OP_ROT_Y, 32'h7FFFFFFF, 0, 0, 0, 0));
		words.push_back(pack_word(rmg_pkg::OP_ROT_Z, 32'h80000000, 0, 0, 0, 0));
		words.push_back(pack_word(rmg_pkg::OP_ROT_X, 32'(90 << 16), 0, 0, 0, 0));
		words.push_back(pack_word(rmg_pkg::OP_ROT_Y, 32'(180 << 16), 0, 0, 0, 0));
		words.push_back(pack_word(rmg_pkg::OP_ROT_Z, 32'(270 << 16), 0, 0, 0, 0));
		words.push_back(pack_word(rmg_pkg::OP_ROT_X, 32'(360 << 16), 0, 0, 0, 0));
		words.push_back(pack_word(rmg_pkg::OP_ROT_Y, 32'((90 << 16) - 1), 0, 0, 0, 0));
		words.push_back(pack_word(rmg_pkg::OP_ROT_Z, 32'hFFFFFFFF, 0, 0, 0, 0));
		words.push_back(pack_word(rmg_pkg::OP_ROT_X, -32'(45 << 16), 0, 0, 0, 0));
		words.push_back(pack_word(rmg_pkg::OP_ROT_Z, 32'(30 << 16), 16'h7FFF, 16'h8000,
			16'h7FFF, 16'h8000));
		words.push_back(pack_word(rmg_pkg::OP_QUAT, 32'hFFFFFFFF, 16'h4000, 0, 0, 0));
		words.push_back(pack_word(rmg_pkg::OP_QUAT, 0, 16'h2D41, 16'h2D41, 0, 0));
		words.push_back(pack_word(rmg_pkg::OP_QUAT, 0, 16'h2000, 16'h2000, 16'h2000,
			16'h2000));
		words.push_back(pack_word(rmg_pkg::OP_QUAT, 0, 16'h7FFF, 16'h7FFF, 16'h7FFF,
			16'h7FFF));
		words.push_back(pack_word(rmg_pkg::OP_QUAT, 0, 16'h8000, 16'h8000, 16'h8000,
			16'h8000));
		words.push_back(pack_word(rmg_pkg::OP_QUAT, 0, 16'h8000, 16'h7FFF, 16'h8000,
			16'h7FFF));
		words.push_back(pack_word(rmg_pkg::OP_QUAT, 0, 0, 0, 0, 0));
		// random: mixed opcodes, angles mostly within a few turns, some full range
		for (int i = 0; i < RANDOM_WORDS; i++) begin
			if ($urandom_range(0, 2) == 0) ang = $urandom();
			else ang = 32'($signed($urandom_range(0, 1440 << 16)) - (720 << 16));
			words.push_back(pack_word(2'($urandom_range(0, 3)), ang,
				rand_q(), rand_q(), rand_q(), rand_q()));
		end
		send_words();
		while (sb.owed.size() > 0) @(posedge clk);
		repeat (40) @(posedge clk);
		$display("sent %0d words (%0d quaternion), checked %0d matrices", sent, n_quat,
			sb.checked);
		if (sb.errors == 0 && sb.owed.size() == 0) begin
			$display("rotation_matrix_generator: match");
		end else begin
			$display("rotation_matrix_generator: mismatch");
		end
		$finish;
	end
endmodule
`default_nettype wire

/* rotation_matrix_generator.f */
hw/rtl/rmg_pkg.sv
hw/rtl/rotation_matrix_generator.sv
test/testbench.sv
